>>> hw/rtl/canopy_snow_mass_release_defines.svh
// Assertion macros for the checks in the top-level block.
`ifndef CANOPY_SNOW_MASS_RELEASE_DEFINES_SVH
`define CANOPY_SNOW_MASS_RELEASE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cms_pkg.sv
package cms_pkg;

    localparam int DATA_W = 32;
    localparam int K_W = 16;

    localparam logic [K_W-1:0] K_THRESH = 16'd6553;
    localparam logic [K_W-1:0] K_RELEASE = 16'd11141;
    localparam logic [DATA_W-1:0] MIN_STORAGE_RST = 32'd83886;

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_REL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic thr_step;
        logic final_step;
        logic clear_t;
        logic release_step;
        logic capture;
        logic limit;
    } t_cmd;

    typedef struct packed {
        logic s_gt_min;
        logic t_ge_thr;
    } t_sts;

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    endfunction

    function automatic t_word umin(input t_word a, input t_word b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> hw/rtl/cms_ifs.sv
interface cms_item_if;
    logic            valid;
    logic            ready;
    cms_pkg::t_word  snow_in;
    cms_pkg::t_word  storage_in;
    cms_pkg::t_word  released_in;
    cms_pkg::t_word  drip_in;

    modport source (output valid, snow_in, storage_in, released_in, drip_in, input ready);
    modport sink (input valid, snow_in, storage_in, released_in, drip_in, output ready);
endinterface

interface cms_result_if;
    logic            valid;
    logic            ready;
    cms_pkg::t_word  snow_out;
    cms_pkg::t_word  storage_out;
    cms_pkg::t_word  released_out;
    cms_pkg::t_word  drip_out;
    logic            limit_hit;

    modport source (
        output valid, snow_out, storage_out, released_out, drip_out, limit_hit,
        input ready
    );
    modport sink (
        input valid, snow_out, storage_out, released_out, drip_out, limit_hit,
        output ready
    );
endinterface

interface cms_cfg_if;
    logic            valid;
    logic            ready;
    cms_pkg::t_word  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/cms_ctrl.sv
module cms_ctrl #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  cms_pkg::t_sts i_sts,
    output cms_pkg::t_cmd o_cmd
);

    localparam int CNT_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(MAX_ROUNDS - 1);

    cms_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_limit, n_limit;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cms_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = cms_pkg::ST_MUL;
                end
            end
            cms_pkg::ST_MUL: begin
                n_state = cms_pkg::ST_EVAL;
            end
            cms_pkg::ST_EVAL: begin
                if (i_sts.s_gt_min && i_sts.t_ge_thr) begin
                    n_state = cms_pkg::ST_REL;
                end else begin
                    n_state = cms_pkg::ST_FIN;
                end
            end
            cms_pkg::ST_REL: begin
                if (r_cnt == LAST_ROUND) begin
                    n_state = cms_pkg::ST_FIN;
                end else begin
                    n_state = cms_pkg::ST_MUL;
                end
            end
            cms_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = cms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.limit = r_limit;
        o_in_ready  = 1'b0;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            cms_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_limit    = 1'b0;
                end
            end
            cms_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            cms_pkg::ST_EVAL: begin
                if (!i_sts.s_gt_min) begin
                    o_cmd.final_step = 1'b1;
                    o_cmd.clear_t    = 1'b1;
                end else if (i_sts.t_ge_thr) begin
                    o_cmd.thr_step = 1'b1;
                end else begin
                    o_cmd.final_step = 1'b1;
                end
            end
            cms_pkg::ST_REL: begin
                o_cmd.release_step = 1'b1;
                if (r_cnt == LAST_ROUND) begin
                    n_limit = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cms_pkg::ST_FIN: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cms_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_limit     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/cms_dp.sv
module cms_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  cms_pkg::t_word i_cfg_data,
    input  cms_pkg::t_word i_snow,
    input  cms_pkg::t_word i_storage,
    input  cms_pkg::t_word i_released,
    input  cms_pkg::t_word i_drip,
    input  cms_pkg::t_cmd  i_cmd,
    output cms_pkg::t_sts  o_sts,
    output cms_pkg::t_word o_snow,
    output cms_pkg::t_word o_storage,
    output cms_pkg::t_word o_released,
    output cms_pkg::t_word o_drip,
    output logic           o_limit
);

    localparam int PROD_W = cms_pkg::DATA_W + cms_pkg::K_W;

    cms_pkg::t_word r_min;
    cms_pkg::t_word r_s, r_t, r_rel, r_drip;
    cms_pkg::t_word r_thr, r_maxrel;
    cms_pkg::t_word r_snow_o, r_stor_o, r_rel_o, r_drip_o;
    logic           r_lim_o;

    logic [PROD_W-1:0] prod_thr, prod_rel;
    cms_pkg::t_word    s_after_thr, excess, rel_amt, fin_amt;

    assign prod_thr = {{cms_pkg::K_W{1'b0}}, r_s} * {{cms_pkg::DATA_W{1'b0}}, cms_pkg::K_THRESH};
    assign prod_rel = {{cms_pkg::K_W{1'b0}}, r_s} * {{cms_pkg::DATA_W{1'b0}}, cms_pkg::K_RELEASE};

    assign o_sts.s_gt_min = r_s > r_min;
    assign o_sts.t_ge_thr = r_t >= r_thr;

    assign s_after_thr = r_s - r_thr;
    assign excess      = r_s - r_min;
    assign rel_amt     = (r_s < r_min) ? '0 : cms_pkg::umin(excess, r_maxrel);
    assign fin_amt     = cms_pkg::umin(r_t, r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= cms_pkg::MIN_STORAGE_RST;
        end else if (i_cfg_valid) begin
            r_min <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s    <= i_snow;
            r_t    <= i_storage;
            r_rel  <= i_released;
            r_drip <= i_drip;
        end else if (i_cmd.thr_step) begin
            r_s    <= s_after_thr;
            r_t    <= r_t - r_thr;
            r_drip <= cms_pkg::sat_add(r_drip, r_thr);
        end else if (i_cmd.release_step) begin
            r_s   <= r_s - rel_amt;
            r_rel <= cms_pkg::sat_add(r_rel, rel_amt);
        end else if (i_cmd.final_step) begin
            r_s    <= r_s - fin_amt;
            r_drip <= cms_pkg::sat_add(r_drip, fin_amt);
            if (i_cmd.clear_t) begin
                r_t <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_thr    <= prod_thr[PROD_W-1:cms_pkg::K_W];
            r_maxrel <= prod_rel[PROD_W-1:cms_pkg::K_W];
        end
        if (i_cmd.capture) begin
            r_snow_o <= r_s;
            r_stor_o <= r_t;
            r_rel_o  <= r_rel;
            r_drip_o <= r_drip;
            r_lim_o  <= i_cmd.limit;
        end
    end

    assign o_snow     = r_snow_o;
    assign o_storage  = r_stor_o;
    assign o_released = r_rel_o;
    assign o_drip     = r_drip_o;
    assign o_limit    = r_lim_o;

endmodule

>>> hw/rtl/canopy_snow_mass_release.sv
// Flow: an accepted transaction is loaded in IDLE; each release round then runs MUL (multiply),
// EVAL (threshold step, or the final step that ends the loop) and REL (release step), and FIN captures
// the result once the output is free. A cell that reaches MAX_ROUNDS sets limit_hit and goes from REL to FIN.
// A new transaction is taken only after the result is captured; the next one is taken while a result waits.
// Reset clears the controller and the output valid and sets min_storage to 83886.
`include "canopy_snow_mass_release_defines.svh"

module canopy_snow_mass_release #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cms_item_if.sink     i_item,
    cms_result_if.source o_result,
    cms_cfg_if.sink      i_cfg
);

    cms_pkg::t_cmd cmd;
    cms_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    cms_ctrl #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_snow      (i_item.snow_in),
        .i_storage   (i_item.storage_in),
        .i_released  (i_item.released_in),
        .i_drip      (i_item.drip_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_snow      (o_result.snow_out),
        .o_storage   (o_result.storage_out),
        .o_released  (o_result.released_out),
        .o_drip      (o_result.drip_out),
        .o_limit     (o_result.limit_hit)
    );

    `CMS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready, "input accepted while busy")
    `CMS_ASSERT_NEXT(a_capture_valid, i_clk, i_rst_n, cmd.capture, o_result.valid, "captured result not presented")
    `CMS_ASSERT_NOW(a_capture_free, i_clk, i_rst_n, cmd.capture, !o_result.valid || o_result.ready, "result overwritten before transaction")

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef cms_pkg::t_word t_word;

    localparam int ROUND_LIMIT = 64;
    localparam logic [15:0] THRESH_FRAC = 16'd6553;
    localparam logic [15:0] RELEASE_FRAC = 16'd11141;
    localparam int DRAIN_CYCLES = 3 * ROUND_LIMIT + 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_CELLS = 250;
    localparam t_word ALL_ONES = 32'hFFFF_FFFF;

    typedef struct {
        t_word snow;
        t_word storage;
        t_word released;
        t_word drip;
    } t_cell;

    typedef struct {
        t_word snow;
        t_word storage;
        t_word released;
        t_word drip;
        logic  limit_hit;
    } t_release;

    logic clk = 1'b0;
    logic rst_n;

    cms_item_if   cell_if ();
    cms_result_if outcome_if ();
    cms_cfg_if    cfg_if ();

    canopy_snow_mass_release #(
        .MAX_ROUNDS(ROUND_LIMIT)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_item(cell_if),
        .o_result(outcome_if),
        .i_cfg(cfg_if)
    );

    t_word    snow_floor = cms_pkg::MIN_STORAGE_RST;
    t_release expected_releases[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       steady = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("canopy_snow_mass_release test failed");
            $finish;
        end
    end

    function automatic t_word frac_of(t_word v, logic [15:0] k);
        logic [63:0] prod;
        prod = {32'd0, v} * {48'd0, k};
        return prod[47:16];
    endfunction

    function automatic t_word add_sat(t_word a, t_word b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, ALL_ONES}) ? ALL_ONES : sum[31:0];
    endfunction

    function automatic t_release predict_release(t_cell c, t_word floor_v);
        t_release res;
        t_word    s;
        t_word    t;
        t_word    thr;
        t_word    cap;
        t_word    r;
        t_word    d;
        logic     done;
        s = c.snow;
        t = c.storage;
        res.released = c.released;
        res.drip = c.drip;
        done = 1'b0;
        for (int rnd = 0; rnd < ROUND_LIMIT && !done; rnd++) begin
            if (s > floor_v) begin
                thr = frac_of(s, THRESH_FRAC);
                cap = frac_of(s, RELEASE_FRAC);
                if (t >= thr) begin
                    res.drip = add_sat(res.drip, thr);
                    s = s - thr;
                    t = t - thr;
                    if (s < floor_v) begin
                        r = '0;
                    end else begin
                        r = (s - floor_v < cap) ? s - floor_v : cap;
                    end
                    res.released = add_sat(res.released, r);
                    s = s - r;
                end else begin
                    d = (t < s) ? t : s;
                    res.drip = add_sat(res.drip, d);
                    s = s - d;
                    done = 1'b1;
                end
            end else begin
                d = (t < s) ? t : s;
                res.drip = add_sat(res.drip, d);
                s = s - d;
                t = '0;
                done = 1'b1;
            end
        end
        res.snow = s;
        res.storage = t;
        res.limit_hit = !done;
        return res;
    endfunction

    function automatic t_cell make_cell(t_word s, t_word t, t_word r, t_word d);
        t_cell c;
        c.snow = s;
        c.storage = t;
        c.released = r;
        c.drip = d;
        return c;
    endfunction

    function automatic t_cell random_cell(t_word floor_v);
        t_cell c;
        c = make_cell($urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 6))
            0: ;
            1: begin
                c.snow = floor_v + t_word'($urandom_range(0, 64));
                c.storage = frac_of(c.snow, THRESH_FRAC) + t_word'($urandom_range(0, 8)) - 4;
            end
            2: c.storage = frac_of(c.snow, THRESH_FRAC) * $urandom_range(1, 5)
                           + t_word'($urandom_range(0, 2)) - 1;
            3: begin
                c.snow = $urandom_range(0, 16);
                c.storage = $urandom_range(0, 16);
            end
            4: begin
                c.released = ALL_ONES - t_word'($urandom_range(0, 1 << 20));
                c.drip = ALL_ONES - t_word'($urandom_range(0, 1 << 20));
                c.storage = c.snow >> $urandom_range(0, 3);
            end
            5: begin
                c.snow = c.snow >> $urandom_range(0, 31);
                c.storage = c.snow >> $urandom_range(0, 6);
            end
            default: c.snow = floor_v - t_word'($urandom_range(0, 64));
        endcase
        return c;
    endfunction

    function automatic void check_word(string field, t_word want, t_word got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endfunction

    task automatic send_cell(t_cell c);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap != 0) begin
            cell_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_if.valid = 1'b1;
        cell_if.snow_in = c.snow;
        cell_if.storage_in = c.storage;
        cell_if.released_in = c.released;
        cell_if.drip_in = c.drip;
        do @(posedge clk); while (!cell_if.ready);
        expected_releases.push_back(predict_release(c, snow_floor));
    endtask

    task automatic settle();
        @(negedge clk);
        cell_if.valid = 1'b0;
        wait (expected_releases.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_min_storage(t_word value);
        settle();
        cfg_if.valid = 1'b1;
        cfg_if.data = value;
        do @(posedge clk); while (!cfg_if.ready);
        snow_floor = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic test_below_floor();
        send_cell(make_cell('0, '0, '0, '0));
        send_cell(make_cell('0, ALL_ONES, ALL_ONES, ALL_ONES));
        send_cell(make_cell(cms_pkg::MIN_STORAGE_RST, 32'd1000, 32'd5, 32'd7));
        send_cell(make_cell(cms_pkg::MIN_STORAGE_RST - 1, ALL_ONES, '0, '0));
    endtask

    task automatic test_threshold_rounds();
        send_cell(make_cell(32'h0100_0000, 32'h0019_9900, '0, '0));
        send_cell(make_cell(32'h0100_0000, 32'h0019_98FF, '0, '0));
        send_cell(make_cell(cms_pkg::MIN_STORAGE_RST + 1, '0, 32'd3, 32'd4));
        send_cell(make_cell(32'd90000, 32'd9000, '0, '0));
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, '0, '0));
    endtask

    task automatic test_total_saturation();
        send_cell(make_cell(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_cell(make_cell(32'hF000_0000, 32'hF000_0000, 32'hFFFF_FF00, 32'hFFFF_FF00));
        send_cell(make_cell(32'h0010_0000, 32'h0010_0000, ALL_ONES, '0));
    endtask

    task automatic test_round_limit();
        write_min_storage('0);
        send_cell(make_cell(32'd1, '0, '0, '0));
        send_cell(make_cell(32'd5, ALL_ONES, 32'd9, 32'd9));
        send_cell(make_cell(32'd6, ALL_ONES, '0, '0));
        send_cell(make_cell(32'd10, '0, '0, '0));
        send_cell(make_cell(ALL_ONES, ALL_ONES, '0, '0));
        send_cell(make_cell('0, 32'd5, '0, '0));
    endtask

    task automatic test_floor_extremes();
        write_min_storage(ALL_ONES);
        send_cell(make_cell(ALL_ONES, ALL_ONES, 32'd3, 32'd3));
        send_cell(make_cell(ALL_ONES, 32'd17, '0, ALL_ONES));
        send_cell(make_cell('0, ALL_ONES, '0, '0));
    endtask

    task automatic test_random_cells();
        t_word floors[7];
        floors[0] = cms_pkg::MIN_STORAGE_RST;
        floors[1] = '0;
        floors[2] = ALL_ONES;
        floors[3] = $urandom;
        floors[4] = $urandom_range(0, 64);
        floors[5] = $urandom >> 8;
        floors[6] = $urandom_range(32'h0100_0000, 32'h1000_0000);
        foreach (floors[p]) begin
            write_min_storage(floors[p]);
            for (int i = 0; i < PHASE_CELLS; i++) begin
                if (i % 50 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                send_cell(random_cell(snow_floor));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        t_release want;
        t_release got;
        int       stall;
        outcome_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                outcome_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            outcome_if.ready = 1'b1;
            do @(posedge clk); while (!outcome_if.valid);
            got.snow = outcome_if.snow_out;
            got.storage = outcome_if.storage_out;
            got.released = outcome_if.released_out;
            got.drip = outcome_if.drip_out;
            got.limit_hit = outcome_if.limit_hit;
            if (expected_releases.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, snow_out %h storage_out %h",
                         $time, got.snow, got.storage);
            end else begin
                want = expected_releases.pop_front();
                check_word("snow_out", want.snow, got.snow);
                check_word("storage_out", want.storage, got.storage);
                check_word("released_out", want.released, got.released);
                check_word("drip_out", want.drip, got.drip);
                check_word("limit_hit", t_word'(want.limit_hit), t_word'(got.limit_hit));
            end
            @(negedge clk);
        end
    end

    initial begin
        cell_if.valid = 1'b0;
        cell_if.snow_in = '0;
        cell_if.storage_in = '0;
        cell_if.released_in = '0;
        cell_if.drip_in = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_below_floor();
        test_threshold_rounds();
        test_total_saturation();
        test_round_limit();
        test_floor_extremes();
        test_random_cells();
        settle();

        if (mismatches == 0 && expected_releases.size() == 0) begin
            $display("canopy_snow_mass_release test passed");
        end else begin
            $display("canopy_snow_mass_release test failed");
        end
        $finish;
    end
endmodule
